// File: hdl/tesr_pkg.sv
package tesr_pkg;

	// speed is unsigned fixed point: WHOLE_W integer bits, FRAC_BITS fraction bits
	localparam int FRAC_BITS = 16;
	localparam int WHOLE_W   = 10;
	localparam int SPEED_W   = WHOLE_W + FRAC_BITS;

	// 100000 + 65535 fits in RATE_W bits
	localparam int RATE_W     = 18;
	localparam int CFG_RATE_W = 16;

	// product of speed and rate factor; quotient may grow by the factor (< 4)
	localparam int NUM_W = SPEED_W + RATE_W;
	localparam int QUO_W = SPEED_W + 2;
	localparam int CNT_W = $clog2(QUO_W);

	localparam int DUTY_W   = 8;
	localparam int ACTION_W = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [RATE_W-1:0]  RATE_SCALE  = RATE_W'(100000);
	localparam logic [DUTY_W-1:0]  DUTY_SCALE  = DUTY_W'(255);
	localparam logic [WHOLE_W-1:0] POWER_LEVEL = WHOLE_W'(50);

	localparam logic [CFG_RATE_W-1:0] ACCEL_RESET    = CFG_RATE_W'(1000);
	localparam logic [CFG_RATE_W-1:0] BRAKE_RESET    = CFG_RATE_W'(1000);
	localparam logic [WHOLE_W-1:0]    DEADBAND_RESET = WHOLE_W'(10);

	localparam logic [REG_IDX_W-1:0] REG_ACCEL    = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_BRAKE    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_DEADBAND = REG_IDX_W'(2);

	// bit positions in ramp_action
	localparam int ACT_BRAKE = 0;
	localparam int ACT_ACCEL = 1;

endpackage

// File: hdl/tesr_if.sv
interface tesr_tick_if;
	logic                            valid;
	logic                            ready;
	logic [tesr_pkg::WHOLE_W-1:0]    throttle_sample;
	logic                            reverser_switch;

	modport source (output valid, output throttle_sample, output reverser_switch, input ready);
	modport sink (input valid, input throttle_sample, input reverser_switch, output ready);
endinterface

interface tesr_status_if;
	logic                            valid;
	logic                            ready;
	logic [tesr_pkg::DUTY_W-1:0]     motor_duty;
	logic                            drive_forward;
	logic                            track_powered;
	logic                            throttle_changed;
	logic [tesr_pkg::WHOLE_W-1:0]    target_speed;
	logic [tesr_pkg::WHOLE_W-1:0]    speed_whole;
	logic [tesr_pkg::ACTION_W-1:0]   ramp_action;

	modport source (output valid, output motor_duty, output drive_forward,
		output track_powered, output throttle_changed, output target_speed,
		output speed_whole, output ramp_action, input ready);
	modport sink (input valid, input motor_duty, input drive_forward,
		input track_powered, input throttle_changed, input target_speed,
		input speed_whole, input ramp_action, output ready);
endinterface

// File: hdl/throttle_exponential_speed_ramp.sv
// Soft-start speed ramp for a throttle-driven motor bridge.
// tick channel: one request per control tick carries the throttle sample and
// the reverser level. status channel: one request per tick carries PWM duty,
// direction, track-powered flag, throttle-changed flag, target, whole speed
// and which ramp steps ran.
// APB port: accel_rate at 0x0, brake_rate at 0x4, throttle_deadband at 0x8;
// write only while no tick is in flight.
// From tick accept the sequencer runs a brake check, a divider pass if
// braking, an accelerate check, and if accelerating a divider pass (or a
// load of 1.0 from zero speed) and a clamp to the target, then loads status.
// Each ramp step from a nonzero speed is one pass of a shared 28-step
// restoring divider fed by a single multiplier; the tick side is ready again
// the cycle after status is loaded.
// The status register holds its request until taken; a finished tick waits
// for it, but a new tick is accepted while a status request is pending.
// Reset: speed and target clear to zero, direction to forward, rates to 1000,
// deadband to 10, status channel empty.
module throttle_exponential_speed_ramp (
	input  logic                          clk,
	input  logic                          arst_n,
	tesr_tick_if.sink                     tick,
	tesr_status_if.source                 status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tesr_pkg::ADDR_W-1:0]   paddr,
	input  logic [tesr_pkg::DATA_W-1:0]   pwdata,
	output logic [tesr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int WHOLE_W  = tesr_pkg::WHOLE_W;
	localparam int SPEED_W  = tesr_pkg::SPEED_W;
	localparam int RATE_W   = tesr_pkg::RATE_W;
	localparam int NUM_W    = tesr_pkg::NUM_W;
	localparam int QUO_W    = tesr_pkg::QUO_W;
	localparam int CNT_W    = tesr_pkg::CNT_W;
	localparam int DUTY_W   = tesr_pkg::DUTY_W;
	localparam int PROD_W   = WHOLE_W + DUTY_W;
	localparam int EST_W    = PROD_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BRAKE_CHK,
		S_DIV,
		S_ACCEL_CHK,
		S_CLAMP,
		S_OUT
	} state_t;

	// configuration
	logic [tesr_pkg::CFG_RATE_W-1:0] accel_q;
	logic [tesr_pkg::CFG_RATE_W-1:0] brake_q;
	logic [WHOLE_W-1:0]              deadband_q;
	logic [tesr_pkg::REG_IDX_W-1:0]  reg_idx;

	// ramp state and sequencer
	state_t                       state_q;
	logic [WHOLE_W-1:0]           target_q;
	logic [SPEED_W-1:0]           speed_q;
	logic                         dir_q;
	logic                         changed_q;
	logic [tesr_pkg::ACTION_W-1:0] action_q;
	logic                         accel_phase_q;

	// shared divider
	logic [RATE_W-1:0]            rem_q;
	logic [QUO_W-1:0]             lo_q;
	logic [RATE_W-1:0]            div_q;
	logic [CNT_W-1:0]             cnt_q;

	// status register
	logic                         out_valid_q;
	logic [DUTY_W-1:0]            out_duty_q;
	logic                         out_fwd_q;
	logic                         out_powered_q;
	logic                         out_changed_q;
	logic [WHOLE_W-1:0]           out_target_q;
	logic [WHOLE_W-1:0]           out_whole_q;
	logic [tesr_pkg::ACTION_W-1:0] out_action_q;

	logic [WHOLE_W-1:0]           whole;
	logic [WHOLE_W-1:0]           diff;
	logic [RATE_W-1:0]            mul_op;
	logic [NUM_W-1:0]             prod;
	logic [RATE_W:0]              trial;
	logic                         ge;
	logic [RATE_W-1:0]            rem_next;
	logic [SPEED_W-1:0]           limit;
	logic [PROD_W-1:0]            duty_prod;
	logic [EST_W-1:0]             duty_sum;
	logic [DUTY_W:0]              duty_est;
	logic [PROD_W-1:0]            duty_rem;
	logic [DUTY_W-1:0]            duty;

	assign reg_idx = paddr[tesr_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q    <= tesr_pkg::ACCEL_RESET;
			brake_q    <= tesr_pkg::BRAKE_RESET;
			deadband_q <= tesr_pkg::DEADBAND_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				tesr_pkg::REG_ACCEL:    accel_q    <= pwdata[tesr_pkg::CFG_RATE_W-1:0];
				tesr_pkg::REG_BRAKE:    brake_q    <= pwdata[tesr_pkg::CFG_RATE_W-1:0];
				tesr_pkg::REG_DEADBAND: deadband_q <= pwdata[WHOLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tesr_pkg::REG_ACCEL:    prdata = tesr_pkg::DATA_W'(accel_q);
			tesr_pkg::REG_BRAKE:    prdata = tesr_pkg::DATA_W'(brake_q);
			tesr_pkg::REG_DEADBAND: prdata = tesr_pkg::DATA_W'(deadband_q);
			default:                prdata = '0;
		endcase
	end

	assign whole = speed_q[SPEED_W-1 -: WHOLE_W];
	assign limit = {target_q, {tesr_pkg::FRAC_BITS{1'b0}}};

	always_comb begin
		if (tick.throttle_sample > target_q)
			diff = tick.throttle_sample - target_q;
		else
			diff = target_q - tick.throttle_sample;
	end

	// braking: speed * 100000 / (100000 + brake)
	// accelerating: speed * (100000 + accel) / 100000
	assign mul_op = (state_q == S_BRAKE_CHK) ? tesr_pkg::RATE_SCALE
		: tesr_pkg::RATE_SCALE + RATE_W'(accel_q);
	assign prod = NUM_W'(speed_q) * NUM_W'(mul_op);

	assign trial    = {rem_q, lo_q[QUO_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_next = ge ? RATE_W'(trial - {1'b0, div_q}) : RATE_W'(trial);

	// duty = whole * 255 / 1023; estimate x*1025/2^20 is low by at most one
	always_comb begin
		duty_prod = PROD_W'(whole) * PROD_W'(tesr_pkg::DUTY_SCALE);
		duty_sum  = EST_W'(duty_prod) + EST_W'(duty_prod >> WHOLE_W);
		duty_est  = (DUTY_W + 1)'(duty_sum >> WHOLE_W);
		duty_rem  = duty_prod - ((PROD_W'(duty_est) << WHOLE_W) - PROD_W'(duty_est));
		if (duty_rem >= PROD_W'({WHOLE_W{1'b1}}))
			duty = DUTY_W'(duty_est + 1'b1);
		else
			duty = DUTY_W'(duty_est);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			target_q      <= '0;
			speed_q       <= '0;
			dir_q         <= 1'b1;
			changed_q     <= 1'b0;
			action_q      <= '0;
			accel_phase_q <= 1'b0;
			rem_q         <= '0;
			lo_q          <= '0;
			div_q         <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
			out_duty_q    <= '0;
			out_fwd_q     <= 1'b0;
			out_powered_q <= 1'b0;
			out_changed_q <= 1'b0;
			out_target_q  <= '0;
			out_whole_q   <= '0;
			out_action_q  <= '0;
		end else begin
			if (out_valid_q && status.ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						if (diff > deadband_q) begin
							target_q  <= tick.throttle_sample;
							changed_q <= 1'b1;
						end else begin
							changed_q <= 1'b0;
						end
						dir_q    <= tick.reverser_switch;
						action_q <= '0;
						state_q  <= S_BRAKE_CHK;
					end
				end
				S_BRAKE_CHK: begin
					if (target_q < whole) begin
						rem_q                <= RATE_W'(prod[NUM_W-1:QUO_W]);
						lo_q                 <= prod[QUO_W-1:0];
						div_q                <= tesr_pkg::RATE_SCALE + RATE_W'(brake_q);
						accel_phase_q        <= 1'b0;
						cnt_q                <= '0;
						action_q[tesr_pkg::ACT_BRAKE] <= 1'b1;
						state_q              <= S_DIV;
					end else begin
						state_q <= S_ACCEL_CHK;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					lo_q  <= {lo_q[QUO_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						if (accel_phase_q) begin
							state_q <= S_CLAMP;
						end else begin
							// braked quotient never exceeds the old speed
							speed_q <= {lo_q[SPEED_W-2:0], ge};
							state_q <= S_ACCEL_CHK;
						end
					end
				end
				S_ACCEL_CHK: begin
					if (target_q > whole) begin
						action_q[tesr_pkg::ACT_ACCEL] <= 1'b1;
						if (speed_q == '0) begin
							lo_q    <= QUO_W'(1) << tesr_pkg::FRAC_BITS;
							state_q <= S_CLAMP;
						end else begin
							rem_q         <= RATE_W'(prod[NUM_W-1:QUO_W]);
							lo_q          <= prod[QUO_W-1:0];
							div_q         <= tesr_pkg::RATE_SCALE;
							accel_phase_q <= 1'b1;
							cnt_q         <= '0;
							state_q       <= S_DIV;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CLAMP: begin
					if (lo_q > QUO_W'(limit))
						speed_q <= limit;
					else
						speed_q <= lo_q[SPEED_W-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || status.ready) begin
						out_valid_q   <= 1'b1;
						out_duty_q    <= duty;
						out_fwd_q     <= dir_q;
						out_powered_q <= whole > tesr_pkg::POWER_LEVEL;
						out_changed_q <= changed_q;
						out_target_q  <= target_q;
						out_whole_q   <= whole;
						out_action_q  <= action_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tick.ready = (state_q == S_IDLE);

	assign status.valid            = out_valid_q;
	assign status.motor_duty       = out_duty_q;
	assign status.drive_forward    = out_fwd_q;
	assign status.track_powered    = out_powered_q;
	assign status.throttle_changed = out_changed_q;
	assign status.target_speed     = out_target_q;
	assign status.speed_whole      = out_whole_q;
	assign status.ramp_action      = out_action_q;

endmodule

// File: hdl/tesr_checker.sv
module tesr_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 tick_valid,
	input logic                                 tick_ready,
	input logic                                 status_valid,
	input logic                                 status_ready,
	input logic [tesr_pkg::DUTY_W-1:0]          motor_duty,
	input logic                                 track_powered,
	input logic [tesr_pkg::WHOLE_W-1:0]         target_speed,
	input logic [tesr_pkg::WHOLE_W-1:0]         speed_whole,
	input logic [tesr_pkg::ACTION_W-1:0]        ramp_action
);

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid)
		else $error("status request dropped while stalled");

	a_status_stable: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=>
			$stable(motor_duty) && $stable(speed_whole) && $stable(target_speed)
			&& $stable(ramp_action))
		else $error("status payload changed while stalled");

	a_powered: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> track_powered == (speed_whole > tesr_pkg::POWER_LEVEL))
		else $error("track_powered disagrees with speed");

	a_accel_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && ramp_action[tesr_pkg::ACT_ACCEL] |-> speed_whole <= target_speed)
		else $error("acceleration passed the target");

	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick accepted while previous one in flight");

endmodule

bind throttle_exponential_speed_ramp tesr_checker u_tesr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.status_valid (status.valid),
	.status_ready (status.ready),
	.motor_duty   (status.motor_duty),
	.track_powered(status.track_powered),
	.target_speed (status.target_speed),
	.speed_whole  (status.speed_whole),
	.ramp_action  (status.ramp_action)
);
